[rtl/sst_pkg.sv]
`default_nettype none

package sst_pkg;

  // Controller steps, one per clock while not waiting for input or for a free output register
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INDEX,
    ST_ROM,
    ST_GAIN,
    ST_MUL,
    ST_OUT
  } state_t;

  // Datapath strobes from the controller
  typedef struct packed {
    logic load_in;
    logic calc_index;
    logic rom_read;
    logic calc_gain;
    logic calc_prod;
    logic load_out;
  } ctrl_cmd_t;

  // Configuration register indexes
  localparam int CFG_INDEX_BITS = 1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_PHASE_STEP = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_DEPTH      = 1'b1;

  localparam int STEP_BITS  = 31;
  localparam int DEPTH_BITS = 16;
  localparam logic [STEP_BITS-1:0]  STEP_RESET  = 31'd357914;
  localparam logic [DEPTH_BITS-1:0] DEPTH_RESET = 16'd16384;
  localparam logic [DEPTH_BITS-1:0] FULL_DEPTH  = 16'd32768;

  // Sine table construction: Q30 Taylor series
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam int TAYLOR_TERMS = 12;
  localparam logic [9:0] FACT_STEP [TAYLOR_TERMS] = '{
    10'd6, 10'd20, 10'd42, 10'd72, 10'd110, 10'd156,
    10'd210, 10'd272, 10'd342, 10'd420, 10'd506, 10'd600
  };

  localparam int ROM_BITS  = 16;
  localparam int GAIN_BITS = 32;

endpackage

`default_nettype wire

[rtl/sst_ctrl.sv]
`default_nettype none

module sst_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output sst_pkg::ctrl_cmd_t     cmd
);
  import sst_pkg::*;

  state_t state;
  state_t state_next;
  logic   slot_free;

  assign slot_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_INDEX;
      end
      ST_INDEX: state_next = ST_ROM;
      ST_ROM:   state_next = ST_GAIN;
      ST_GAIN:  state_next = ST_MUL;
      ST_MUL:   state_next = ST_OUT;
      ST_OUT: begin
        if (slot_free) state_next = ST_IDLE;
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
      end
      ST_INDEX: cmd.calc_index = 1'b1;
      ST_ROM:   cmd.rom_read   = 1'b1;
      ST_GAIN:  cmd.calc_gain  = 1'b1;
      ST_MUL:   cmd.calc_prod  = 1'b1;
      ST_OUT:   cmd.load_out   = slot_free;
      default: begin
        cmd      = '0;
        in_ready = 1'b0;
      end
    endcase
  end

  // Output register valid: set on load, drop once the transfer is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  a_load_only_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("result loaded over an untaken result");

  a_accept_starts_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == ST_INDEX))
    else $error("accepted frame did not start processing");

  a_load_gives_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> out_valid)
    else $error("loaded result not presented");

  a_no_accept_while_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !cmd.load_in)
    else $error("frame loaded while busy");

endmodule

`default_nettype wire

[rtl/sst_datapath.sv]
`default_nettype none

module sst_datapath #(
  parameter int SAMPLE_BITS      = 24,
  parameter int PHASE_BITS       = 32,
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire sst_pkg::ctrl_cmd_t                     cmd,
  input  wire logic                                   cfg_valid,
  input  wire logic [sst_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
  input  wire logic [sst_pkg::STEP_BITS-1:0]          cfg_data,
  input  wire logic signed [SAMPLE_BITS-1:0]          left_sample,
  input  wire logic signed [SAMPLE_BITS-1:0]          right_sample,
  output logic signed [SAMPLE_BITS-1:0]               left_out,
  output logic signed [SAMPLE_BITS-1:0]               right_out
);
  import sst_pkg::*;

  localparam int QB            = PHASE_BITS - 2;
  localparam int ROM_ADDR_BITS = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int PROD_BITS     = SAMPLE_BITS + GAIN_BITS + 1;
  localparam logic [ROM_ADDR_BITS-1:0] DEPTH_W = ROM_ADDR_BITS'(SINE_TABLE_DEPTH);
  localparam logic [16:0] MID_U = 17'd32768;
  localparam logic [32:0] ONE_Q31 = 33'h0_8000_0000;
  localparam logic signed [PROD_BITS-1:0] ROUND_HALF =
    {{(PROD_BITS-31){1'b0}}, 1'b1, 30'd0};

  typedef logic [ROM_BITS-1:0] sine_rom_t [0:SINE_TABLE_DEPTH];

  // Quarter-wave table, Q1.15, entry k = sin(pi*k / (2*depth))
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t   rom;
    logic [63:0] theta;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] q;
    for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
      theta = (HALF_PI_Q30 * 64'(k)) / SINE_TABLE_DEPTH;
      term  = theta;
      sum   = '0;
      for (int n = 0; n < TAYLOR_TERMS; n++) begin
        if ((n % 2) == 0) sum = sum + term;
        else              sum = sum - term;
        term = (term * theta) >> 30;
        term = (term * theta) >> 30;
        term = term / 64'(FACT_STEP[n]);
      end
      q = (sum + 64'd16384) >> 15;
      if (q > 64'(FULL_DEPTH)) q = 64'(FULL_DEPTH);
      rom[k] = q[ROM_BITS-1:0];
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

  logic [STEP_BITS-1:0]               phase_step;
  logic [DEPTH_BITS-1:0]              depth;
  logic [PHASE_BITS-1:0]              phase;
  logic [PHASE_BITS-1:0]              step_scaled;
  logic signed [SAMPLE_BITS-1:0]      left_r;
  logic signed [SAMPLE_BITS-1:0]      right_r;
  logic [1:0]                         quad;
  logic [ROM_ADDR_BITS-1:0]           idx;
  logic [QB+ROM_ADDR_BITS-1:0]        idx_prod;
  logic [ROM_ADDR_BITS-1:0]           rom_addr;
  logic [ROM_BITS-1:0]                rom_q;
  logic [16:0]                        u;
  logic [GAIN_BITS-1:0]               gain;
  logic signed [PROD_BITS-1:0]        prod_l;
  logic signed [PROD_BITS-1:0]        prod_r;
  logic signed [PROD_BITS-1:0]        sum_l;
  logic signed [PROD_BITS-1:0]        sum_r;

  // Configuration; depth above full acts as full
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step <= STEP_RESET;
      depth      <= DEPTH_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_PHASE_STEP: phase_step <= cfg_data;
        CFG_DEPTH: begin
          depth <= (cfg_data[DEPTH_BITS-1:0] > FULL_DEPTH) ? FULL_DEPTH
                                                            : cfg_data[DEPTH_BITS-1:0];
        end
        default: ;
      endcase
    end
  end

  // Step is in units of 2^-32 of a full LFO period; scale to the accumulator width
  generate
    if (PHASE_BITS >= 32) begin : g_step_up
      assign step_scaled = {{(PHASE_BITS-STEP_BITS){1'b0}}, phase_step} << (PHASE_BITS-32);
    end else begin : g_step_down
      assign step_scaled = {1'b0, phase_step[STEP_BITS-1:32-PHASE_BITS]};
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
    end else if (cmd.load_in) begin
      phase <= phase + step_scaled;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      left_r  <= left_sample;
      right_r <= right_sample;
    end
  end

  // Table index = fraction of the quadrant times table depth
  assign idx_prod = {{ROM_ADDR_BITS{1'b0}}, phase[QB-1:0]} * {{QB{1'b0}}, DEPTH_W};

  always_ff @(posedge clk) begin
    if (cmd.calc_index) begin
      quad <= phase[PHASE_BITS-1:PHASE_BITS-2];
      idx  <= idx_prod[QB+ROM_ADDR_BITS-1:QB];
    end
  end

  // Odd quadrants run the table backward
  assign rom_addr = quad[0] ? (DEPTH_W - idx) : idx;

  always_ff @(posedge clk) begin
    if (cmd.rom_read) begin
      rom_q <= SINE_ROM[rom_addr];
    end
  end

  // u = 0.5 + 0.5*sin in Q1.16, gain = 1 - depth*u in Q31
  assign u = quad[1] ? (MID_U - {1'b0, rom_q}) : (MID_U + {1'b0, rom_q});

  always_ff @(posedge clk) begin
    if (cmd.calc_gain) begin
      gain <= GAIN_BITS'(ONE_Q31 - ({17'd0, depth} * {16'd0, u}));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.calc_prod) begin
      prod_l <= left_r * $signed({1'b0, gain});
      prod_r <= right_r * $signed({1'b0, gain});
    end
  end

  // Round to nearest, ties toward plus infinity
  assign sum_l = prod_l + ROUND_HALF;
  assign sum_r = prod_r + ROUND_HALF;

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      left_out  <= sum_l[SAMPLE_BITS+30:31];
      right_out <= sum_r[SAMPLE_BITS+30:31];
    end
  end

endmodule

`default_nettype wire

[rtl/stereo_sine_tremolo_top.sv]
// Sine-LFO tremolo on a stream of stereo frames.
// Input channel s_axis_*: one frame per transfer, left sample in the low
// SAMPLE_BITS of tdata, right sample above it (signed Q1.23 by default).
// Output channel m_axis_*: the same frame scaled by the tremolo gain
// 1 - depth*(0.5 + 0.5*sin(phase)); the gain never exceeds one.
// Configuration channel cfg_*: index 0 writes the phase step (31 bits, in
// units of 2^-32 LFO period per frame), index 1 writes depth (Q1.15 taken
// from the low 16 data bits, values above 32768 act as 32768). cfg_ready is
// always high; write only while idle. Each frame first advances the LFO
// phase by the step, then reads the sine. The controller walks phase, table
// index, table read, gain, multiply and output load in turn, and takes no
// new frame until the last one is loaded into the output register.
// The next frame is taken while a finished result waits in the output
// register; if the receiver stalls, the block holds its next result in the
// last step until the output register frees up.
// Reset clears the LFO phase to zero and loads the default step and depth.
`default_nettype none

module stereo_sine_tremolo_top #(
  parameter int SAMPLE_BITS      = 24,
  parameter int PHASE_BITS       = 32,
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  wire logic                                          clk,
  input  wire logic                                          rst,
  input  wire logic                                          s_axis_tvalid,
  output logic                                               s_axis_tready,
  // left_sample, right_sample
  input  wire logic [((2*SAMPLE_BITS+7)/8)*8-1:0]            s_axis_tdata,
  output logic                                               m_axis_tvalid,
  input  wire logic                                          m_axis_tready,
  // left_out, right_out
  output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]                 m_axis_tdata,
  input  wire logic                                          cfg_valid,
  output logic                                               cfg_ready,
  input  wire logic [sst_pkg::CFG_INDEX_BITS-1:0]            cfg_index,
  input  wire logic [sst_pkg::STEP_BITS-1:0]                 cfg_data
);
  import sst_pkg::*;

  localparam int TDATA_BITS = ((2*SAMPLE_BITS+7)/8)*8;

  ctrl_cmd_t                     cmd;
  logic signed [SAMPLE_BITS-1:0] left_out;
  logic signed [SAMPLE_BITS-1:0] right_out;

  assign cfg_ready = 1'b1;

  sst_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .cmd       (cmd)
  );

  sst_datapath #(
    .SAMPLE_BITS      (SAMPLE_BITS),
    .PHASE_BITS       (PHASE_BITS),
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .left_sample  (s_axis_tdata[SAMPLE_BITS-1:0]),
    .right_sample (s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
    .left_out     (left_out),
    .right_out    (right_out)
  );

  assign m_axis_tdata = TDATA_BITS'({right_out, left_out});

endmodule

`default_nettype wire

[tb/tremolo_checker.sv]
`timescale 1ns / 100ps

module tremolo_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  input  logic                              s_tready,
  input  logic [47:0]                       s_tdata,
  input  logic                              m_tvalid,
  input  logic                              m_tready,
  input  logic [47:0]                       m_tdata,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [sst_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [sst_pkg::STEP_BITS-1:0]     cfg_data,
  output int                                fail_count,
  output int                                pending
);
  import sst_pkg::*;

  localparam int TABLE_DEPTH = 1024;

  // left in the low half, right above it
  typedef struct packed {
    logic signed [23:0] right;
    logic signed [23:0] left;
  } frame_t;

  int unsigned sine_quarter [0:TABLE_DEPTH];
  logic [31:0] phase_acc;
  logic [STEP_BITS-1:0] step_reg;
  logic [DEPTH_BITS-1:0] depth_reg;
  frame_t expected_frames [$];

  // Q15 quarter sine, Q30 Taylor series with truncated products
  function automatic int unsigned quarter_sine_q15(int unsigned k);
    logic [63:0] theta, term, acc, q;
    theta = (HALF_PI_Q30 * 64'(k)) / 64'(TABLE_DEPTH);
    term = theta;
    acc = '0;
    for (int n = 0; n < 12; n++) begin
      if (n % 2 == 0) acc = acc + term;
      else acc = acc - term;
      term = (term * theta) >> 30;
      term = (term * theta) >> 30;
      term = term / 64'((2 * n + 2) * (2 * n + 3));
    end
    q = (acc + 64'd16384) >> 15;
    if (q > 64'd32768) q = 64'd32768;
    return int'(q);
  endfunction

  // sample * gain / 2^31, round half up
  function automatic logic [23:0] scale_sample(logic signed [23:0] smp, longint gain);
    longint acc;
    acc = smp;
    acc = acc * gain + (longint'(1) <<< 30);
    acc = acc >>> 31;
    return acc[23:0];
  endfunction

  function automatic frame_t tremolo_frame(logic [31:0] ph, logic [15:0] dep, frame_t in_f);
    logic [9:0] idx;
    longint sine_val, gain;
    frame_t out_f;
    idx = ph[29:20];
    sine_val = ph[30] ? sine_quarter[TABLE_DEPTH - idx] : sine_quarter[idx];
    if (ph[31]) sine_val = -sine_val;
    gain = (longint'(1) <<< 31) - longint'(dep) * (sine_val + 32768);
    out_f.left = scale_sample(in_f.left, gain);
    out_f.right = scale_sample(in_f.right, gain);
    return out_f;
  endfunction

  initial begin
    for (int k = 0; k <= TABLE_DEPTH; k++) sine_quarter[k] = quarter_sine_q15(k);
  end

  always @(posedge clk) begin
    frame_t got, want;
    if (rst) begin
      phase_acc = '0;
      step_reg = STEP_RESET;
      depth_reg = DEPTH_RESET;
      fail_count = 0;
      expected_frames.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (expected_frames.size() == 0) begin
          $display("%0t unexpected transfer: expected none actual left %0d right %0d",
                   $time, got.left, got.right);
          fail_count = fail_count + 1;
        end else begin
          want = expected_frames.pop_front();
          if (got.left !== want.left) begin
            $display("%0t left_out mismatch: expected %0d actual %0d",
                     $time, want.left, got.left);
            fail_count = fail_count + 1;
          end
          if (got.right !== want.right) begin
            $display("%0t right_out mismatch: expected %0d actual %0d",
                     $time, want.right, got.right);
            fail_count = fail_count + 1;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_PHASE_STEP: step_reg = cfg_data;
          CFG_DEPTH: begin
            // clamp the low 16 data bits at full depth
            depth_reg = (cfg_data[15:0] > FULL_DEPTH) ? FULL_DEPTH : cfg_data[15:0];
          end
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        // advance first, then read the sine at the new phase
        phase_acc = phase_acc + 32'(step_reg);
        expected_frames.push_back(tremolo_frame(phase_acc, depth_reg, frame_t'(s_tdata)));
      end
    end
    pending <= expected_frames.size();
  end

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps

module tb;
  import sst_pkg::*;

  localparam int RANDOM_FRAMES = 800;
  localparam int CYCLE_LIMIT   = 250000;
  localparam logic [23:0] S_MAX = 24'h7FFFFF;
  localparam logic [23:0] S_MIN = 24'h800000;
  localparam logic [23:0] S_ONE = 24'h000001;
  localparam logic [23:0] S_NEG = 24'hFFFFFF;

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_CADENCE} rx_mode_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      s_axis_tvalid = 1'b0;
  logic                      s_axis_tready;
  logic [47:0]               s_axis_tdata = '0;
  logic                      m_axis_tvalid;
  logic                      m_axis_tready = 1'b0;
  logic [47:0]               m_axis_tdata;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = CFG_PHASE_STEP;
  logic [STEP_BITS-1:0]      cfg_data = '0;
  int                        fail_count;
  int                        pending;
  int                        cycle_count = 0;

  // sender bookkeeping
  int          burst_left = 0;
  logic [31:0] phase_track = '0;
  logic [30:0] step_now = STEP_RESET;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  stereo_sine_tremolo_top DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  tremolo_checker checker_inst (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_axis_tvalid),
    .s_tready   (s_axis_tready),
    .s_tdata    (s_axis_tdata),
    .m_tvalid   (m_axis_tvalid),
    .m_tready   (m_axis_tready),
    .m_tdata    (m_axis_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // receiver: random stall patterns, plus long hold-offs so the block backs up
  initial begin : receiver
    rx_mode_t mode;
    int mode_left, taken, next_hold, cadence;
    mode = RX_OPEN;
    mode_left = 0;
    taken = 0;
    next_hold = 200;
    cadence = 0;
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (m_axis_tvalid && m_axis_tready) taken++;
      if (taken >= next_hold) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(250, 350)) @(posedge clk);
        next_hold += 350;
      end else begin
        if (mode_left == 0) begin
          mode = rx_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(5, 80);
        end
        mode_left--;
        cadence++;
        case (mode)
          RX_OPEN:    m_axis_tready <= 1'b1;
          RX_COIN:    m_axis_tready <= 1'($urandom_range(0, 1));
          RX_SPARSE:  m_axis_tready <= ($urandom_range(0, 5) == 0);
          RX_CADENCE: m_axis_tready <= (cadence % 5 != 4);
          default:    m_axis_tready <= 1'b1;
        endcase
      end
    end
  end

  function automatic logic [23:0] rand_sample();
    case ($urandom_range(0, 15))
      0:       return S_MAX;
      1:       return S_MIN;
      2:       return '0;
      3:       return S_NEG;
      4:       return S_ONE;
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [30:0] pick_step();
    case ($urandom_range(0, 5))
      0:       return 31'($urandom);
      1:       return 31'($urandom_range(0, 2000000));
      2:       return '0;
      3:       return 31'h7FFFFFFF;
      4:       return 31'h40000000;
      default: return 31'($urandom_range(1, 100));
    endcase
  endfunction

  function automatic logic [30:0] pick_depth();
    case ($urandom_range(0, 5))
      0:       return 31'($urandom_range(0, 65535));
      1:       return '0;
      2:       return 31'(FULL_DEPTH);
      3:       return 31'd32767;
      4:       return 31'($urandom_range(0, 32768));
      default: return 31'($urandom);
    endcase
  endfunction

  task automatic send_frame(input logic [23:0] left, input logic [23:0] right);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {right, left};
    do @(posedge clk); while (!s_axis_tready);
    phase_track = phase_track + 32'(step_now);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150) : $urandom_range(0, 30);
      gap = $urandom_range(1, 9);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end else begin
      burst_left--;
    end
  endtask

  // hold the sender until every outstanding frame has come back
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_INDEX_BITS-1:0] idx, input logic [30:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_lfo(input logic [30:0] step_val, input logic [30:0] depth_val);
    if ($urandom_range(0, 1)) begin
      cfg_write(CFG_DEPTH, depth_val);
      cfg_write(CFG_PHASE_STEP, step_val);
    end else begin
      cfg_write(CFG_PHASE_STEP, step_val);
      cfg_write(CFG_DEPTH, depth_val);
    end
    cfg_valid <= 1'b0;
    step_now = step_val;
  endtask

  initial begin : stimulus
    int sent, run_len;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // default step and depth straight out of reset
    send_frame(S_MAX, S_MIN);
    send_frame(S_MIN, S_MAX);
    send_frame('0, '0);
    send_frame(S_NEG, S_ONE);
    send_frame(S_ONE, S_NEG);
    send_frame(S_MAX, S_MAX);
    wait_drained();

    // largest step; depth above full with high data bits set
    set_lfo(31'h7FFFFFFF, 31'h7FFF8001);
    send_frame(S_MAX, S_MIN);
    send_frame(S_MIN, S_MIN);
    send_frame(S_MAX, '0);
    send_frame(S_NEG, S_MAX);
    wait_drained();

    // land the phase on a quadrant boundary, then walk all four quadrants
    set_lfo(31'((~phase_track + 32'd1) & 32'h3FFFFFFF), 31'(FULL_DEPTH));
    send_frame(S_MAX, S_MIN);
    wait_drained();
    set_lfo(31'h40000000, 31'(FULL_DEPTH));
    send_frame(S_MAX, S_MIN);
    send_frame(S_MIN, S_MAX);
    send_frame(S_MAX, S_NEG);
    send_frame(S_MIN, S_ONE);
    wait_drained();

    // no step, no depth: frames pass through unchanged
    set_lfo('0, '0);
    send_frame(S_MAX, S_MIN);
    send_frame(S_NEG, S_ONE);
    wait_drained();

    set_lfo(31'd1, 31'd32767);
    send_frame(S_MIN, S_MAX);
    send_frame(S_ONE, S_NEG);
    wait_drained();

    sent = 0;
    while (sent < RANDOM_FRAMES) begin
      set_lfo(pick_step(), pick_depth());
      run_len = $urandom_range(40, 120);
      repeat (run_len) send_frame(rand_sample(), rand_sample());
      sent += run_len;
      wait_drained();
    end

    repeat (12) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[stereo_sine_tremolo_top.f]
rtl/sst_pkg.sv
rtl/sst_ctrl.sv
rtl/sst_datapath.sv
rtl/stereo_sine_tremolo_top.sv
tb/tremolo_checker.sv
tb/tb.sv
